// File: design/hdp_pkg.sv
// shared types, constants and class tables of the halfword instruction predecoder
`default_nettype none

package hdp_pkg;

  localparam int unsigned HalfW  = 16;
  localparam int unsigned PcW    = 32;
  localparam int unsigned AvailW = 3;
  localparam int unsigned SizeW  = 3;
  localparam int unsigned ClassW = 5;
  localparam int unsigned ImmW   = 12;

  localparam logic [PcW-1:0]    PageMask   = 32'hFFFF_F000;
  localparam int unsigned       LongBit    = 15;
  localparam logic [3:0]        CondAlways = 4'd15;
  localparam logic [AvailW-1:0] AvailShort = 3'd2;
  localparam logic [AvailW-1:0] AvailLong  = 3'd4;
  localparam logic [SizeW-1:0]  SizeNone   = 3'd0;
  localparam logic [SizeW-1:0]  SizeShort  = 3'd2;
  localparam logic [SizeW-1:0]  SizeLong   = 3'd4;
  localparam logic [PcW-1:0]    FallStep   = 32'd2;

  typedef enum logic [ClassW-1:0] {
    CLS_NONE  = 5'd0,
    CLS_NOP   = 5'd1,
    CLS_MOV   = 5'd2,
    CLS_CJMP  = 5'd3,
    CLS_CMP   = 5'd4,
    CLS_CCALL = 5'd5,
    CLS_UNK   = 5'd6,
    CLS_ADD   = 5'd7,
    CLS_SUB   = 5'd8,
    CLS_AND   = 5'd9,
    CLS_OR    = 5'd10,
    CLS_NOT   = 5'd11,
    CLS_XOR   = 5'd12,
    CLS_LOAD  = 5'd13,
    CLS_POP   = 5'd14,
    CLS_STORE = 5'd15,
    CLS_PUSH  = 5'd16,
    CLS_JMP   = 5'd17,
    CLS_SHL   = 5'd18,
    CLS_ILL   = 5'd19,
    CLS_SHR   = 5'd20
  } op_class_e;

  typedef enum logic [1:0] {
    TGT_NONE,
    TGT_PAGE,
    TGT_REL
  } tgt_kind_e;

  // decoded item leaving the first stage
  typedef struct packed {
    op_class_e       cls;
    logic [SizeW-1:0] size;
    tgt_kind_e       kind;
    logic            need_fall;
    logic            eob;
    logic [PcW-1:0]  pc;
    logic [ImmW-1:0] imm;
  } dec_t;

  // item leaving the address stage, relative target still to be added
  typedef struct packed {
    op_class_e        cls;
    logic [SizeW-1:0] size;
    logic             eob;
    logic             rel;
    logic [PcW-1:0]   pc;
    logic [PcW-1:0]   off;
    logic [PcW-1:0]   tgt;
    logic [PcW-1:0]   fall;
  } addr_t;

  function automatic op_class_e major2_class(input logic [3:0] sel);
    op_class_e c;
    case (sel)
      4'd0:    c = CLS_ADD;
      4'd1:    c = CLS_SUB;
      4'd2:    c = CLS_SUB;
      4'd3:    c = CLS_CMP;
      4'd4:    c = CLS_AND;
      4'd5:    c = CLS_OR;
      4'd6:    c = CLS_NOT;
      4'd7:    c = CLS_XOR;
      4'd8:    c = CLS_LOAD;
      4'd9:    c = CLS_LOAD;
      4'd10:   c = CLS_POP;
      4'd11:   c = CLS_LOAD;
      4'd12:   c = CLS_STORE;
      4'd13:   c = CLS_STORE;
      4'd14:   c = CLS_PUSH;
      default: c = CLS_STORE;
    endcase
    return c;
  endfunction

  // bit clear maps to or, bit set maps to and
  function automatic op_class_e major6_class(input logic [2:0] sel);
    op_class_e c;
    case (sel)
      3'd0:    c = CLS_ADD;
      3'd1:    c = CLS_SHL;
      3'd2:    c = CLS_ILL;
      3'd3:    c = CLS_SHR;
      3'd4:    c = CLS_OR;
      3'd5:    c = CLS_AND;
      3'd6:    c = CLS_CMP;
      default: c = CLS_UNK;
    endcase
    return c;
  endfunction

  function automatic op_class_e major7_class(input logic [2:0] sel);
    op_class_e c;
    case (sel)
      3'd0:    c = CLS_LOAD;
      3'd1:    c = CLS_LOAD;
      3'd2:    c = CLS_UNK;
      3'd3:    c = CLS_LOAD;
      3'd4:    c = CLS_STORE;
      3'd5:    c = CLS_STORE;
      3'd6:    c = CLS_STORE;
      default: c = CLS_UNK;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/hdp_if.sv
// valid/ready channel interfaces for halfword and decode transfers
`default_nettype none

interface hdp_in_if;
  logic                         valid;
  logic                         ready;
  logic [hdp_pkg::HalfW-1:0]    insn_half;
  logic [hdp_pkg::PcW-1:0]      pc_address;
  logic [hdp_pkg::AvailW-1:0]   bytes_available;

  modport source (output valid, insn_half, pc_address, bytes_available, input ready);
  modport sink   (input valid, insn_half, pc_address, bytes_available, output ready);
endinterface

interface hdp_out_if;
  logic                         valid;
  logic                         ready;
  logic [hdp_pkg::ClassW-1:0]   op_class;
  logic [hdp_pkg::SizeW-1:0]    insn_size;
  logic [hdp_pkg::PcW-1:0]      jump_target;
  logic [hdp_pkg::PcW-1:0]      fallthrough_addr;
  logic                         ends_block;

  modport source (output valid, op_class, insn_size, jump_target, fallthrough_addr,
                  ends_block, input ready);
  modport sink   (input valid, op_class, insn_size, jump_target, fallthrough_addr,
                  ends_block, output ready);
endinterface

`default_nettype wire

// File: design/hdp_decode_stage.sv
// first pipeline stage: field decode, class lookup and size
`default_nettype none

module hdp_decode_stage (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output      logic                         ready_o,
  input  wire logic [hdp_pkg::HalfW-1:0]    insn_half_i,
  input  wire logic [hdp_pkg::PcW-1:0]      pc_address_i,
  input  wire logic [hdp_pkg::AvailW-1:0]   bytes_available_i,
  output      logic                         valid_o,
  input  wire logic                         ready_i,
  output      hdp_pkg::dec_t                dec_o
);

  logic          valid_q;
  hdp_pkg::dec_t dec_d, dec_q;
  logic [2:0]    major;
  logic [3:0]    lo4, mid4;

  assign major = insn_half_i[14:12];
  assign lo4   = insn_half_i[3:0];
  assign mid4  = insn_half_i[11:8];

  always_comb begin
    dec_d.cls       = hdp_pkg::CLS_NONE;
    dec_d.size      = hdp_pkg::SizeNone;
    dec_d.kind      = hdp_pkg::TGT_NONE;
    dec_d.need_fall = 1'b0;
    dec_d.eob       = 1'b0;
    dec_d.pc        = pc_address_i;
    dec_d.imm       = insn_half_i[hdp_pkg::ImmW-1:0];
    if (bytes_available_i >= hdp_pkg::AvailShort) begin
      if (insn_half_i[hdp_pkg::LongBit]) begin
        if (bytes_available_i >= hdp_pkg::AvailLong) begin
          dec_d.size = hdp_pkg::SizeLong;
        end
      end else begin
        dec_d.size = hdp_pkg::SizeShort;
        case (major)
          3'd0: begin
            if (lo4 == 4'd0) begin
              dec_d.cls = hdp_pkg::CLS_NOP;
            end else if (lo4 inside {[4'd1:4'd3]}) begin
              dec_d.cls = hdp_pkg::CLS_MOV;
            end else if (lo4 == 4'd4) begin
              // register branch
              dec_d.cls       = hdp_pkg::CLS_CJMP;
              dec_d.need_fall = 1'b1;
              dec_d.eob       = 1'b1;
            end else if (lo4 == 4'd5) begin
              dec_d.cls = hdp_pkg::CLS_CMP;
            end else if (lo4 == 4'd12) begin
              // register call
              dec_d.cls       = hdp_pkg::CLS_CCALL;
              dec_d.need_fall = 1'b1;
              dec_d.eob       = 1'b1;
            end else begin
              dec_d.cls = hdp_pkg::CLS_UNK;
            end
          end
          3'd1: begin
            dec_d.cls = (lo4 inside {[4'd0:4'd1]} && mid4 inside {[4'd0:4'd1]})
                        ? hdp_pkg::CLS_MOV : hdp_pkg::CLS_UNK;
          end
          3'd2: dec_d.cls = hdp_pkg::major2_class(lo4);
          3'd3: begin
            dec_d.cls  = hdp_pkg::CLS_JMP;
            dec_d.kind = hdp_pkg::TGT_PAGE;
            dec_d.eob  = 1'b1;
          end
          3'd4: begin
            dec_d.kind = hdp_pkg::TGT_REL;
            if (mid4 == hdp_pkg::CondAlways) begin
              dec_d.cls = hdp_pkg::CLS_JMP;
            end else begin
              dec_d.cls       = hdp_pkg::CLS_CJMP;
              dec_d.need_fall = 1'b1;
            end
          end
          3'd5:    dec_d.cls = hdp_pkg::CLS_LOAD;
          3'd6:    dec_d.cls = hdp_pkg::major6_class(insn_half_i[2:0]);
          default: dec_d.cls = hdp_pkg::major7_class(insn_half_i[2:0]);
        endcase
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

`default_nettype wire

// File: design/hdp_addr_stage.sv
// second pipeline stage: fall-through increment, page target, branch offset
`default_nettype none

module hdp_addr_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output      logic           ready_o,
  input  wire hdp_pkg::dec_t  dec_i,
  output      logic           valid_o,
  input  wire logic           ready_i,
  output      hdp_pkg::addr_t addr_o
);

  logic           valid_q;
  hdp_pkg::addr_t addr_d, addr_q;

  always_comb begin
    addr_d.cls  = dec_i.cls;
    addr_d.size = dec_i.size;
    addr_d.eob  = dec_i.eob;
    addr_d.rel  = 1'b0;
    addr_d.pc   = dec_i.pc;
    // sign-extended 8-bit displacement in halfwords
    addr_d.off  = {{(hdp_pkg::PcW-9){dec_i.imm[7]}}, dec_i.imm[7:0], 1'b0};
    addr_d.tgt  = '0;
    addr_d.fall = dec_i.need_fall ? (dec_i.pc + hdp_pkg::FallStep) : '0;
    case (dec_i.kind)
      hdp_pkg::TGT_PAGE: begin
        addr_d.tgt = (dec_i.pc & hdp_pkg::PageMask) |
                     {{(hdp_pkg::PcW-hdp_pkg::ImmW){1'b0}}, dec_i.imm[11:1], 1'b0};
      end
      hdp_pkg::TGT_REL: addr_d.rel = 1'b1;
      default:          addr_d.rel = 1'b0;
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      addr_q <= addr_d;
    end
  end

  assign valid_o = valid_q;
  assign addr_o  = addr_q;

endmodule

`default_nettype wire

// File: design/halfword_insn_predecoder_core.sv
// top level of the halfword instruction predecoder: three-stage pipeline
`default_nettype none

// halfword instruction predecoder
//
// in_i carries one fetched halfword, its 32-bit address and the count of bytes
// present; out_o returns the class, instruction size, direct jump target,
// fall-through address and end-of-block flag for it. both are valid/ready
// channels; a transfer happens on a clock edge with valid and ready high.
//
// three register stages: decode (class and size), address (pc + 2 and page
// target), result (pc-relative target add, output register). an item passes
// the decode, address and output registers in that order before out_o.valid
// rises for it; one item per cycle is taken and delivered as long as the
// receiver keeps ready high, since every stage loads whenever it is empty or
// its successor moves on.
//
// when the receiver stalls, the output register holds its item and the stages
// behind it keep filling; in_i.ready drops only once all three are occupied.
// reset (rst_ni low, asynchronous) empties the pipeline; the block keeps no
// other state.
module halfword_insn_predecoder_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hdp_in_if.sink    in_i,
  hdp_out_if.source out_o
);

  // decode stage
  logic          s1_valid, s1_ready;
  hdp_pkg::dec_t s1_dec;

  // address stage
  logic           s2_valid, s2_ready;
  hdp_pkg::addr_t s2_addr;

  // result stage registers
  logic                        out_valid_q;
  logic                        out_ready;
  hdp_pkg::op_class_e          cls_q;
  logic [hdp_pkg::SizeW-1:0]   size_q;
  logic [hdp_pkg::PcW-1:0]     tgt_d, tgt_q;
  logic [hdp_pkg::PcW-1:0]     fall_q;
  logic                        eob_q;

  hdp_decode_stage u_decode (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (in_i.valid),
    .ready_o           (in_i.ready),
    .insn_half_i       (in_i.insn_half),
    .pc_address_i      (in_i.pc_address),
    .bytes_available_i (in_i.bytes_available),
    .valid_o           (s1_valid),
    .ready_i           (s1_ready),
    .dec_o             (s1_dec)
  );

  hdp_addr_stage u_addr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .dec_i   (s1_dec),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .addr_o  (s2_addr)
  );

  // pc-relative target add, wraps at 32 bits
  assign tgt_d = s2_addr.rel ? (s2_addr.pc + s2_addr.off) : s2_addr.tgt;

  // output register loads when empty or when its item is being taken
  assign out_ready = out_o.ready;
  assign s2_ready  = !out_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s2_valid) begin
      cls_q  <= s2_addr.cls;
      size_q <= s2_addr.size;
      tgt_q  <= tgt_d;
      fall_q <= s2_addr.fall;
      eob_q  <= s2_addr.eob;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.op_class         = cls_q;
  assign out_o.insn_size        = size_q;
  assign out_o.jump_target      = tgt_q;
  assign out_o.fallthrough_addr = fall_q;
  assign out_o.ends_block       = eob_q;

  // input back-pressure only when every stage holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid && s2_valid && out_valid_q))
    else $error("input stalled with a free pipeline stage");

  // a stalled decode stage keeps its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !s1_ready) |=> (s1_valid && $stable(s1_dec)))
    else $error("decode stage item changed while stalled");

  // short input yields an all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && size_q == hdp_pkg::SizeNone) |->
      (cls_q == hdp_pkg::CLS_NONE && tgt_q == '0 && fall_q == '0 && !eob_q))
    else $error("result with size zero carries nonzero fields");

  // only 16-bit instructions end a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && eob_q) |-> (size_q == hdp_pkg::SizeShort))
    else $error("end of block on an instruction that is not 16 bits");

endmodule

`default_nettype wire

// File: tb/tb_halfword_insn_predecoder_core.sv
// self-checking testbench of the halfword instruction predecoder with its own decode predictor
import hdp_pkg::*;

// result fields of one decoded halfword
typedef struct packed {
  op_class_e         cls;
  logic [SizeW-1:0]  size;
  logic [PcW-1:0]    tgt;
  logic [PcW-1:0]    fall;
  logic              eob;
} predecode_t;

class predecode_tracker;
  predecode_t expected_decodes[$];
  int unsigned mismatch_count = 0;

  task report_mismatch(string what);
    $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  function int unsigned pending();
    return expected_decodes.size();
  endfunction

  // class, size, target, fall-through and end-of-block for one halfword
  function predecode_t predecode(logic [HalfW-1:0] h, logic [PcW-1:0] pc,
                                 logic [AvailW-1:0] avail);
    predecode_t d;
    logic [3:0]     lo4;
    logic [3:0]     mid4;
    logic [PcW-1:0] off;
    lo4    = h[3:0];
    mid4   = h[11:8];
    off    = {{24{h[7]}}, h[7:0]};
    d.cls  = CLS_NONE;
    d.size = SizeNone;
    d.tgt  = '0;
    d.fall = '0;
    d.eob  = 1'b0;
    if (avail >= 3'd2) begin
      if (h[15]) begin
        if (avail >= 3'd4) d.size = SizeLong;
      end else begin
        d.size = SizeShort;
        case (h[14:12])
          3'd0: begin
            if (lo4 == 4'd0) d.cls = CLS_NOP;
            else if (lo4 <= 4'd3) d.cls = CLS_MOV;
            else if (lo4 == 4'd4) begin
              d.cls  = CLS_CJMP;
              d.fall = pc + 32'd2;
              d.eob  = 1'b1;
            end else if (lo4 == 4'd5) d.cls = CLS_CMP;
            else if (lo4 == 4'd12) begin
              d.cls  = CLS_CCALL;
              d.fall = pc + 32'd2;
              d.eob  = 1'b1;
            end else d.cls = CLS_UNK;
          end
          3'd1: d.cls = (lo4 <= 4'd1 && mid4 <= 4'd1) ? CLS_MOV : CLS_UNK;
          3'd2: begin
            case (lo4)
              4'd0:                 d.cls = CLS_ADD;
              4'd1, 4'd2:           d.cls = CLS_SUB;
              4'd3:                 d.cls = CLS_CMP;
              4'd4:                 d.cls = CLS_AND;
              4'd5:                 d.cls = CLS_OR;
              4'd6:                 d.cls = CLS_NOT;
              4'd7:                 d.cls = CLS_XOR;
              4'd8, 4'd9, 4'd11:    d.cls = CLS_LOAD;
              4'd10:                d.cls = CLS_POP;
              4'd14:                d.cls = CLS_PUSH;
              default:              d.cls = CLS_STORE;
            endcase
          end
          3'd3: begin
            d.cls = CLS_JMP;
            d.tgt = (pc & PageMask) | {20'd0, h[11:1], 1'b0};
            d.eob = 1'b1;
          end
          3'd4: begin
            if (mid4 == CondAlways) d.cls = CLS_JMP;
            else begin
              d.cls  = CLS_CJMP;
              d.fall = pc + 32'd2;
            end
            d.tgt = pc + (off << 1);
          end
          3'd5: d.cls = CLS_LOAD;
          3'd6: begin
            // bit clear gives or, bit set gives and
            case (h[2:0])
              3'd0:    d.cls = CLS_ADD;
              3'd1:    d.cls = CLS_SHL;
              3'd2:    d.cls = CLS_ILL;
              3'd3:    d.cls = CLS_SHR;
              3'd4:    d.cls = CLS_OR;
              3'd5:    d.cls = CLS_AND;
              3'd6:    d.cls = CLS_CMP;
              default: d.cls = CLS_UNK;
            endcase
          end
          default: begin
            case (h[2:0])
              3'd0, 3'd1, 3'd3: d.cls = CLS_LOAD;
              3'd4, 3'd5, 3'd6: d.cls = CLS_STORE;
              default:          d.cls = CLS_UNK;
            endcase
          end
        endcase
      end
    end
    return d;
  endfunction

  function void note_input(logic [HalfW-1:0] h, logic [PcW-1:0] pc, logic [AvailW-1:0] avail);
    expected_decodes.push_back(predecode(h, pc, avail));
  endfunction

  task check_result(logic [ClassW-1:0] cls, logic [SizeW-1:0] size, logic [PcW-1:0] tgt,
                    logic [PcW-1:0] fall, logic eob);
    predecode_t e;
    if (expected_decodes.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected (class %0d)", cls));
    end else begin
      e = expected_decodes.pop_front();
      if (cls !== e.cls)
        report_mismatch($sformatf("op_class %0d, want %0d", cls, e.cls));
      if (size !== e.size)
        report_mismatch($sformatf("insn_size %0d, want %0d", size, e.size));
      if (tgt !== e.tgt)
        report_mismatch($sformatf("jump_target %h, want %h", tgt, e.tgt));
      if (fall !== e.fall)
        report_mismatch($sformatf("fallthrough_addr %h, want %h", fall, e.fall));
      if (eob !== e.eob)
        report_mismatch($sformatf("ends_block %b, want %b", eob, e.eob));
    end
  endtask
endclass

module tb_halfword_insn_predecoder_core;
  localparam int unsigned NumRandom = 850;
  localparam int unsigned DrainWait = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   no_idle = 1'b0;

  hdp_in_if  in_ch ();
  hdp_out_if out_ch ();

  predecode_tracker tracker = new();

  halfword_insn_predecoder_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #10 clk_i = ~clk_i;

  // receiver: stalls about a quarter of the cycles unless in a quiet stretch
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 25);
    end
  end

  // both channels are sampled together; results leave before newer inputs are noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready)
        tracker.check_result(out_ch.op_class, out_ch.insn_size, out_ch.jump_target,
                             out_ch.fallthrough_addr, out_ch.ends_block);
      if (in_ch.valid && in_ch.ready)
        tracker.note_input(in_ch.insn_half, in_ch.pc_address, in_ch.bytes_available);
    end
  end

  // present one halfword and return at the edge of its transfer
  task send_halfword(logic [HalfW-1:0] h, logic [PcW-1:0] pc, logic [AvailW-1:0] avail);
    in_ch.valid           <= 1'b1;
    in_ch.insn_half       <= h;
    in_ch.pc_address      <= pc;
    in_ch.bytes_available <= avail;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // random sender gap after a transfer
  task sender_gap();
    if (!no_idle && $urandom_range(0, 99) < 25) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
  endtask

  // mostly well-formed 16-bit encodings, biased toward the interesting minor fields
  function automatic logic [HalfW-1:0] pick_halfword();
    logic [HalfW-1:0] h;
    h = 16'($urandom);
    if ($urandom_range(0, 9) >= 2) begin
      h[15]    = 1'b0;
      h[14:12] = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 1) begin
        case (h[14:12])
          3'd0: h[3:0] = ($urandom_range(0, 6) == 6) ? 4'd12 : 4'($urandom_range(0, 5));
          3'd1: begin
            h[3:0]  = 4'($urandom_range(0, 2));
            h[11:8] = 4'($urandom_range(0, 2));
          end
          3'd4: h[11:8] = CondAlways;
          default: ;
        endcase
      end
    end
    return h;
  endfunction

  function automatic logic [PcW-1:0] pick_pc();
    if ($urandom_range(0, 7) == 0) return 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
    return 32'($urandom);
  endfunction

  function automatic logic [AvailW-1:0] pick_avail();
    if ($urandom_range(0, 4) == 0) return 3'($urandom_range(0, 7));
    return 3'($urandom_range(2, 7));
  endfunction

  initial begin
    in_ch.valid           <= 1'b0;
    in_ch.insn_half       <= '0;
    in_ch.pc_address      <= '0;
    in_ch.bytes_available <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // long instruction: enough bytes, one short, counts above four
    send_halfword(16'hFFFF, 32'h0000_1000, 3'd4);            sender_gap();
    send_halfword(16'h8000, 32'h0000_1000, 3'd3);            sender_gap();
    send_halfword(16'hC123, 32'hFFFF_FFFF, 3'd7);            sender_gap();
    // too few bytes for a short instruction
    send_halfword(16'h0004, 32'h0000_0100, 3'd0);            sender_gap();
    send_halfword(16'h3FFF, 32'h0000_0100, 3'd1);            sender_gap();
    // major 0: nop, mov, register branch, cmp, register call, unknown
    send_halfword(16'h0000, 32'h0000_0000, 3'd2);            sender_gap();
    send_halfword(16'h0013, 32'h1234_5678, 3'd2);            sender_gap();
    send_halfword(16'h0F04, 32'hFFFF_FFFE, 3'd5);            sender_gap();
    send_halfword(16'h0005, 32'h0000_0002, 3'd2);            sender_gap();
    send_halfword(16'h0AAC, 32'hFFFF_FFFF, 3'd6);            sender_gap();
    send_halfword(16'h0FFF, 32'h8000_0000, 3'd2);            sender_gap();
    // major 1: mov and unknown
    send_halfword(16'h1101, 32'h0000_4000, 3'd2);            sender_gap();
    send_halfword(16'h1200, 32'h0000_4000, 3'd2);            sender_gap();
    // major 2 table
    send_halfword(16'h2A5E, 32'h0000_0040, 3'd4);            sender_gap();
    // page jump with every address bit set
    send_halfword(16'h3FFF, 32'hFFFF_FFFF, 3'd2);            sender_gap();
    // relative branch: always with most negative offset, conditional wrapping forward
    send_halfword(16'h4F80, 32'h0000_0000, 3'd2);            sender_gap();
    send_halfword(16'h407F, 32'hFFFF_FFFE, 3'd2);            sender_gap();
    // major 5 load
    send_halfword(16'h5555, 32'h7FFF_FFFF, 3'd3);            sender_gap();
    // major 6: bit clear, bit set, unknown
    send_halfword(16'h6004, 32'h0000_2000, 3'd2);            sender_gap();
    send_halfword(16'h6FF5, 32'h0000_2000, 3'd2);            sender_gap();
    send_halfword(16'h6007, 32'h0000_2000, 3'd2);            sender_gap();
    // major 7 unknown slot
    send_halfword(16'h7FFA, 32'h0000_2000, 3'd2);            sender_gap();

    for (int unsigned n = 0; n < NumRandom; n++) begin
      // quiet stretch: neither side idles
      no_idle = (n >= 300 && n < 450);
      send_halfword(pick_halfword(), pick_pc(), pick_avail());
      if (n == 500) begin
        // hold off until the pipeline has drained completely
        in_ch.valid <= 1'b0;
        do @(posedge clk_i); while (tracker.pending() != 0);
      end else begin
        sender_gap();
      end
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk_i); while (tracker.pending() != 0);
    repeat (DrainWait) @(posedge clk_i);
    if (tracker.mismatch_count == 0) begin
      $display("[halfword_insn_predecoder_core] OK");
    end else begin
      $display("[halfword_insn_predecoder_core] ERROR");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #4000000;
    $display("[halfword_insn_predecoder_core] ERROR");
    $finish;
  end
endmodule
